// ===== rtl/idiv_pkg.sv =====
// ----------------------------------------------------------------------------
// idiv_pkg
// shared data width and the pipeline stage record of the 32-bit integer divider
// ----------------------------------------------------------------------------
package idiv_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic [DATA_W-1:0] rest;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] quo;
        logic              neg_q;
        logic              dbz;
    } t_stage;

endpackage

// ===== rtl/idiv_ifs.sv =====
// ----------------------------------------------------------------------------
// idiv_ifs
// valid/ready channels for divider requests and results
// ----------------------------------------------------------------------------
interface idiv_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [idiv_pkg::DATA_W-1:0] dividend;
    logic [idiv_pkg::DATA_W-1:0] divisor_in;

    modport source (output valid, func, dividend, divisor_in, input ready);
    modport sink   (input valid, func, dividend, divisor_in, output ready);
endinterface

interface idiv_out_if;
    logic                        valid;
    logic                        ready;
    logic [idiv_pkg::DATA_W-1:0] quotient;
    logic [idiv_pkg::DATA_W-1:0] remainder;
    logic                        divide_by_zero;

    modport source (output valid, quotient, remainder, divide_by_zero, input ready);
    modport sink   (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface

// ===== rtl/idiv_cell.sv =====
// ----------------------------------------------------------------------------
// idiv_cell
// one restoring step: trial subtract of the divisor shifted by SHIFT, then register
// ----------------------------------------------------------------------------
module idiv_cell #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  idiv_pkg::t_stage i_stage,
    output logic             o_valid,
    output idiv_pkg::t_stage o_stage
);
    import idiv_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage = i_stage;
        // rest >= den * 2^SHIFT without widening
        if ((i_stage.rest >> SHIFT) >= i_stage.den) begin
            n_stage.rest       = i_stage.rest - (i_stage.den << SHIFT);
            n_stage.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== rtl/integer_divider_32_unit.sv =====
// ----------------------------------------------------------------------------
// integer_divider_32_unit
// pipelined 32-bit unsigned/signed integer divider with remainder
// ----------------------------------------------------------------------------
// Accepts one request per cycle unless stalled, returns one result per request,
// in order. A request passes one operand stage, a row of 32 restoring-step
// cells (one quotient bit each, most significant first) and one result stage,
// the operand stage loading at the accepting edge.
// The whole row advances together whenever the result register is empty or
// being taken, and i_req.ready is that same enable. Signed mode divides the
// magnitudes and negates the quotient when the signs differ; the remainder is
// the magnitude remainder. A zero divisor sets divide_by_zero with an all-ones
// quotient and the raw dividend as remainder.
module integer_divider_32_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idiv_in_if.sink     i_req,
    idiv_out_if.source  o_rsp
);
    import idiv_pkg::*;

    logic              en;
    logic              neg_a;
    logic              neg_b;
    logic              dbz;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    t_stage            n_s0;

    logic              r_v0;
    t_stage            r_s0;

    logic              v   [DATA_W+1];
    t_stage            s   [DATA_W+1];

    logic              r_out_valid;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic              r_dbz;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    // operand stage
    always_comb begin
        neg_a = i_req.func && i_req.dividend[DATA_W-1];
        neg_b = i_req.func && i_req.divisor_in[DATA_W-1];
        dbz   = (i_req.divisor_in == '0);
        mag_a = neg_a ? (DATA_W'(0) - i_req.dividend)   : i_req.dividend;
        mag_b = neg_b ? (DATA_W'(0) - i_req.divisor_in) : i_req.divisor_in;
        n_s0.rest  = dbz ? i_req.dividend : mag_a;
        n_s0.den   = mag_b;
        n_s0.quo   = '0;
        n_s0.neg_q = !dbz && (neg_a != neg_b);
        n_s0.dbz   = dbz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign v[0] = r_v0;
    assign s[0] = r_s0;

    // row of restoring cells
    for (genvar k = 0; k < DATA_W; k++) begin : g_cell
        idiv_cell #(
            .SHIFT (DATA_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k]),
            .i_stage (s[k]),
            .o_valid (v[k+1]),
            .o_stage (s[k+1])
        );
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v[DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quo <= s[DATA_W].neg_q ? (DATA_W'(0) - s[DATA_W].quo) : s[DATA_W].quo;
            r_rem <= s[DATA_W].rest;
            r_dbz <= s[DATA_W].dbz;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.quotient       = r_quo;
    assign o_rsp.remainder      = r_rem;
    assign o_rsp.divide_by_zero = r_dbz;

    a_dbz_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_by_zero |-> o_rsp.quotient == '1)
        else $error("divide by zero result without all-ones quotient");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[DATA_W] && !s[DATA_W].dbz |-> s[DATA_W].rest < s[DATA_W].den)
        else $error("remainder not below divisor at end of cell row");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v[DATA_W]) && $stable(r_v0) && $stable(s[DATA_W]))
        else $error("pipeline moved while result stalled");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the pipelined 32-bit integer divider
// ----------------------------------------------------------------------------
// A queue of division requests feeds a driver that applies each request's gap. A
// monitor predicts each accepted request's quotient, remainder and divide-by-
// zero flag, and checks every result in order against that prediction. The
// result side stalls at random. Directed requests cover the corner operands
// of both modes, then random operands of mixed magnitudes follow.
// ----------------------------------------------------------------------------
module tb_top;
    import idiv_pkg::*;

    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;
    localparam int   LATENCY       = 34;
    localparam int   RANDOM_DIVS   = 830;

    typedef struct {
        logic              func;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
        int unsigned       gap;
        bit                drain;
    } t_div_req;

    typedef struct {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
        logic              dbz;
    } t_div_rsp;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    idiv_in_if  div_req ();
    idiv_out_if div_rsp ();

    integer_divider_32_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    t_div_req    pending_divs[$];
    t_div_rsp    divs_due[$];
    t_div_req    staged_div;
    bit          staged     = 1'b0;
    bit          req_taken  = 1'b0;
    bit          rsp_taken  = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned rsp_count  = 0;
    int unsigned fails      = 0;

    always #4 clk = ~clk;

    function automatic t_div_rsp divide(logic func, logic [DATA_W-1:0] a,
                                        logic [DATA_W-1:0] b);
        t_div_rsp          r;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic              neg_q;
        r.dbz = 1'b0;
        if (b == '0) begin
            r.quotient  = '1;
            r.remainder = a;
            r.dbz       = 1'b1;
            return r;
        end
        mag_a = a;
        mag_b = b;
        neg_q = 1'b0;
        if (func == FUNC_SIGNED) begin
            if (a[DATA_W-1]) mag_a = '0 - a;
            if (b[DATA_W-1]) mag_b = '0 - b;
            neg_q = a[DATA_W-1] ^ b[DATA_W-1];
        end
        r.quotient  = mag_a / mag_b;
        r.remainder = mag_a % mag_b;
        if (neg_q) r.quotient = '0 - r.quotient;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 15);
            1: return $urandom >> $urandom_range(0, 31);
            2: return 32'd1 << $urandom_range(0, 31);
            3: return '0 - $urandom_range(1, 16);
            4: return $urandom | 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_div(logic func, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                           int unsigned gap, bit drain);
        t_div_req d;
        d.func     = func;
        d.dividend = a;
        d.divisor  = b;
        d.gap      = gap;
        d.drain    = drain;
        pending_divs.push_back(d);
    endtask

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            div_req.valid <= 1'b0;
        end else if (!div_req.valid || req_taken) begin
            if (!staged && pending_divs.size() != 0) begin
                staged_div = pending_divs.pop_front();
                staged     = 1'b1;
                gap_left   = staged_div.gap;
            end
            if (staged && gap_left == 0 && !(staged_div.drain && divs_due.size() != 0)) begin
                div_req.valid      <= 1'b1;
                div_req.func       <= staged_div.func;
                div_req.dividend   <= staged_div.dividend;
                div_req.divisor_in <= staged_div.divisor;
                staged = 1'b0;
            end else begin
                if (gap_left > 0) gap_left--;
                div_req.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            div_rsp.ready <= 1'b0;
        end else begin
            if (rsp_taken)
                stall_left = ((rsp_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 9);
            if (stall_left > 0) begin
                stall_left--;
                div_rsp.ready <= 1'b0;
            end else begin
                div_rsp.ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        t_div_rsp want;
        req_taken <= rst_n && div_req.valid && div_req.ready === 1'b1;
        rsp_taken <= rst_n && div_rsp.valid === 1'b1 && div_rsp.ready;
        if (rst_n && div_rsp.valid === 1'b1 && div_rsp.ready) begin
            rsp_count++;
            if (divs_due.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
            end else begin
                want = divs_due.pop_front();
                if (div_rsp.quotient !== want.quotient) begin
                    $error("quotient: expected %h, actual %h", want.quotient, div_rsp.quotient);
                    fails++;
                end
                if (div_rsp.remainder !== want.remainder) begin
                    $error("remainder: expected %h, actual %h",
                           want.remainder, div_rsp.remainder);
                    fails++;
                end
                if (div_rsp.divide_by_zero !== want.dbz) begin
                    $error("divide_by_zero: expected %b, actual %b",
                           want.dbz, div_rsp.divide_by_zero);
                    fails++;
                end
            end
        end
        if (rst_n && div_req.valid && div_req.ready === 1'b1)
            divs_due.push_back(divide(div_req.func, div_req.dividend, div_req.divisor_in));
    end

    initial begin
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        div_req.valid      = 1'b0;
        div_req.func       = FUNC_UNSIGNED;
        div_req.dividend   = '0;
        div_req.divisor_in = '0;
        div_rsp.ready      = 1'b0;

        // corner operands, unsigned
        add_div(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 0, 1'b1);
        add_div(FUNC_UNSIGNED, 32'hffff_ffff, 32'h0000_0001, 0, 1'b0);
        add_div(FUNC_UNSIGNED, 32'hffff_ffff, 32'hffff_ffff, 1, 1'b0);
        add_div(FUNC_UNSIGNED, 32'hffff_ffff, 32'h0000_0002, 0, 1'b0);
        add_div(FUNC_UNSIGNED, 32'h0000_0001, 32'hffff_ffff, 2, 1'b0);
        add_div(FUNC_UNSIGNED, 32'h1234_5678, 32'h0000_0000, 0, 1'b0);
        add_div(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_div(FUNC_UNSIGNED, 32'h8000_0000, 32'h8000_0000, 3, 1'b0);
        add_div(FUNC_UNSIGNED, 32'h0000_0007, 32'h0000_0003, 0, 1'b0);
        add_div(FUNC_UNSIGNED, 32'hdead_beef, 32'h0001_0000, 0, 1'b0);
        // corner operands, signed
        add_div(FUNC_SIGNED, 32'h8000_0000, 32'hffff_ffff, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h8000_0000, 32'h0000_0001, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h8000_0000, 32'h8000_0000, 4, 1'b0);
        add_div(FUNC_SIGNED, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h0000_0001, 32'h8000_0000, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h7fff_ffff, 32'hffff_ffff, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'hffff_fff9, 32'h0000_0002, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h0000_0007, 32'hffff_fffe, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'hffff_fff9, 32'hffff_fffe, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'hffff_ffff, 32'h0000_0000, 0, 1'b0);
        add_div(FUNC_SIGNED, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);

        for (int i = 0; i < RANDOM_DIVS; i++) begin
            a = pick_operand();
            b = ($urandom_range(0, 39) == 0) ? '0 : pick_operand();
            add_div(1'($urandom_range(0, 1)), a, b,
                    ((i / 50) % 4 == 1) ? 0 : $urandom_range(0, 9),
                    i == 300 || i == 600);
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_divs.size() != 0 || staged || div_req.valid) @(posedge clk);
        while (divs_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/idiv_pkg.sv
rtl/idiv_ifs.sv
rtl/idiv_cell.sv
rtl/integer_divider_32_unit.sv
verif/tb_top.sv
